/* src/wpsd_pkg.sv */
// Package for the WAV PCM stream decoder: phase codes, result kinds, error codes,
// chunk identifiers and the record passed from the front part to the back part.
// No dependencies.
package wpsd_pkg;

  typedef enum logic [3:0] {
    PH_RIFF_ID    = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_ID    = 4'd2,
    PH_FMT_ID     = 4'd3,
    PH_FMT_SIZE   = 4'd4,
    PH_FMT_BODY   = 4'd5,
    PH_FMT_EXTRA  = 4'd6,
    PH_CHUNK_ID   = 4'd7,
    PH_CHUNK_SIZE = 4'd8,
    PH_SKIP       = 4'd9,
    PH_DATA       = 4'd10,
    PH_DONE       = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_ID    = 3'd1,
    ERR_NOT_PCM   = 3'd2,
    ERR_BAD_FMT   = 3'd3,
    ERR_NO_DATA   = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_e;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] RATE_A  = 32'd44100;
  localparam logic [31:0] RATE_B  = 32'd48000;

  // Queue depth between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One beat's worth of work for the back part: up to two results.
  typedef struct packed {
    logic        r0_vld;
    kind_e       r0_kind;
    logic [31:0] r0_a;     // mono sample, or first channel, or rate
    logic [31:0] r0_b;     // second channel for stereo averaging, or payload size
    logic        r0_avg;   // average a and b
    logic [15:0] r0_ch;
    logic [5:0]  r0_bits;
    logic        r0_warn;
    err_e        r0_err;
    logic        r1_vld;   // second result is always an end-of-stream error
    err_e        r1_err;
  } work_t;

endpackage

/* src/wpsd_front.sv */
// Front part of the WAV PCM stream decoder: parses the byte stream and produces
// a work record per beat that causes results. Uses wpsd_pkg.
module wpsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wpsd_pkg::work_t   q_data_o
);

  wpsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [5:0]  bits_q, bits_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bis_q, bis_d;
  logic [15:0] cif_q, cif_d;
  logic [31:0] first_q, first_d;
  logic        failed_q, failed_d;

  logic        take;
  logic [31:0] id_sh, size_sh, acc_sh;
  logic        four;
  logic [15:0] bits16;
  logic [2:0]  bps;
  logic [31:0] rem_m1;
  wpsd_pkg::work_t w;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign id_sh      = {data_byte_i, id_q[31:8]};
  assign size_sh    = {data_byte_i, size_q[31:8]};
  assign four       = (fcnt_q[1:0] == 2'd3);
  assign bps        = bits_q[5:3];
  assign rem_m1     = rem_q - 32'd1;
  assign acc_sh     = {data_byte_i, ((bis_q == 2'd0) ? 24'd0 : acc_q[31:8])};
  assign bits16     = {data_byte_i, size_q[7:0]};

  always_comb begin
    phase_d = phase_q; fcnt_d = fcnt_q; id_d = id_q; size_d = size_q; rem_d = rem_q;
    fmt_d = fmt_q; ch_d = ch_q; rate_d = rate_q; bits_d = bits_q; acc_d = acc_q;
    bis_d = bis_q; cif_d = cif_q; first_d = first_q; failed_d = failed_q;
    w = '0;
    w.r0_kind = wpsd_pkg::KIND_SAMPLE;
    w.r0_err  = wpsd_pkg::ERR_NONE;
    w.r1_err  = wpsd_pkg::ERR_NONE;
    case (phase_q)
      wpsd_pkg::PH_RIFF_ID, wpsd_pkg::PH_WAVE_ID, wpsd_pkg::PH_FMT_ID: begin
        id_d = id_sh;
        fcnt_d = four ? 4'd0 : fcnt_q + 4'd1;
        if (four) begin
          if ((phase_q == wpsd_pkg::PH_RIFF_ID && id_sh != wpsd_pkg::ID_RIFF) ||
              (phase_q == wpsd_pkg::PH_WAVE_ID && id_sh != wpsd_pkg::ID_WAVE) ||
              (phase_q == wpsd_pkg::PH_FMT_ID && id_sh != wpsd_pkg::ID_FMT)) begin
            w.r0_vld = 1'b1; w.r0_kind = wpsd_pkg::KIND_ERROR;
            w.r0_err = wpsd_pkg::ERR_BAD_ID;
            failed_d = 1'b1; phase_d = wpsd_pkg::PH_DONE;
          end else if (phase_q == wpsd_pkg::PH_RIFF_ID) begin
            phase_d = wpsd_pkg::PH_RIFF_SIZE;
          end else if (phase_q == wpsd_pkg::PH_WAVE_ID) begin
            phase_d = wpsd_pkg::PH_FMT_ID;
          end else begin
            phase_d = wpsd_pkg::PH_FMT_SIZE;
          end
        end
      end
      wpsd_pkg::PH_RIFF_SIZE: begin
        size_d = size_sh;
        fcnt_d = four ? 4'd0 : fcnt_q + 4'd1;
        if (four) phase_d = wpsd_pkg::PH_WAVE_ID;
      end
      wpsd_pkg::PH_FMT_SIZE: begin
        size_d = size_sh;
        fcnt_d = four ? 4'd0 : fcnt_q + 4'd1;
        if (four) begin
          rem_d = size_sh; size_d = '0; fmt_d = '0; ch_d = '0; rate_d = '0;
          phase_d = wpsd_pkg::PH_FMT_BODY;
        end
      end
      wpsd_pkg::PH_FMT_BODY: begin
        case (fcnt_q)
          4'd0: fmt_d[7:0] = data_byte_i;
          4'd1: fmt_d[15:8] = data_byte_i;
          4'd2: ch_d[7:0] = data_byte_i;
          4'd3: ch_d[15:8] = data_byte_i;
          4'd4: rate_d[7:0] = data_byte_i;
          4'd5: rate_d[15:8] = data_byte_i;
          4'd6: rate_d[23:16] = data_byte_i;
          4'd7: rate_d[31:24] = data_byte_i;
          4'd14: size_d[7:0] = data_byte_i;
          default: ;
        endcase
        fcnt_d = fcnt_q + 4'd1;
        if (fcnt_q == 4'd15) begin
          size_d = '0;
          bits_d = bits16[5:0];
          if (fmt_q != 16'd1) begin
            w.r0_vld = 1'b1; w.r0_kind = wpsd_pkg::KIND_ERROR;
            w.r0_err = wpsd_pkg::ERR_NOT_PCM;
            failed_d = 1'b1; phase_d = wpsd_pkg::PH_DONE;
          end else if ((bits16 != 16'd16 && bits16 != 16'd24 && bits16 != 16'd32) ||
                       ch_q == 16'd0) begin
            w.r0_vld = 1'b1; w.r0_kind = wpsd_pkg::KIND_ERROR;
            w.r0_err = wpsd_pkg::ERR_BAD_FMT;
            failed_d = 1'b1; phase_d = wpsd_pkg::PH_DONE;
          end else begin
            rem_d = (rem_q > 32'd16) ? rem_q - 32'd16 : 32'd0;
            phase_d = (rem_q > 32'd16) ? wpsd_pkg::PH_FMT_EXTRA : wpsd_pkg::PH_CHUNK_ID;
          end
        end
      end
      wpsd_pkg::PH_FMT_EXTRA, wpsd_pkg::PH_SKIP: begin
        rem_d = rem_m1;
        if (rem_m1 == 32'd0) phase_d = wpsd_pkg::PH_CHUNK_ID;
      end
      wpsd_pkg::PH_CHUNK_ID: begin
        id_d = id_sh;
        fcnt_d = four ? 4'd0 : fcnt_q + 4'd1;
        if (four) phase_d = wpsd_pkg::PH_CHUNK_SIZE;
      end
      wpsd_pkg::PH_CHUNK_SIZE: begin
        size_d = size_sh;
        fcnt_d = four ? 4'd0 : fcnt_q + 4'd1;
        if (four) begin
          rem_d = size_sh;
          if (id_q == wpsd_pkg::ID_DATA) begin
            w.r0_vld = 1'b1; w.r0_kind = wpsd_pkg::KIND_HEADER;
            w.r0_a = rate_q; w.r0_b = size_sh; w.r0_ch = ch_q; w.r0_bits = bits_q;
            w.r0_warn = (rate_q != wpsd_pkg::RATE_A) && (rate_q != wpsd_pkg::RATE_B);
            acc_d = '0; bis_d = '0; cif_d = '0; first_d = '0;
            phase_d = (size_sh != 32'd0) ? wpsd_pkg::PH_DATA : wpsd_pkg::PH_DONE;
          end else begin
            phase_d = (size_sh != 32'd0) ? wpsd_pkg::PH_SKIP : wpsd_pkg::PH_CHUNK_ID;
          end
        end
      end
      wpsd_pkg::PH_DATA: begin
        acc_d = acc_sh;
        if ({1'b0, bis_q} + 3'd1 >= bps) begin
          bis_d = 2'd0;
          if (cif_q == 16'd0) first_d = acc_sh;
          if ({1'b0, cif_q} + 17'd1 >= {1'b0, ch_q}) begin
            w.r0_vld = 1'b1;
            w.r0_a = (cif_q == 16'd0) ? acc_sh : first_q;
            w.r0_b = acc_sh;
            w.r0_avg = (ch_q == 16'd2);
            cif_d = '0;
          end else begin
            cif_d = cif_q + 16'd1;
          end
        end else begin
          bis_d = bis_q + 2'd1;
        end
        rem_d = rem_m1;
        if (rem_m1 == 32'd0) phase_d = wpsd_pkg::PH_DONE;
      end
      default: ;
    endcase
    if (last_byte_i) begin
      if (!failed_d && phase_d != wpsd_pkg::PH_DONE) begin
        w.r1_vld = 1'b1;
        w.r1_err = (phase_d == wpsd_pkg::PH_DATA) ? wpsd_pkg::ERR_TRUNCATED
                                                  : wpsd_pkg::ERR_NO_DATA;
      end
      phase_d = wpsd_pkg::PH_RIFF_ID; fcnt_d = '0; id_d = '0; size_d = '0; rem_d = '0;
      fmt_d = '0; ch_d = '0; rate_d = '0; bits_d = '0; acc_d = '0; bis_d = '0;
      cif_d = '0; first_d = '0; failed_d = 1'b0;
    end
  end

  assign q_push_o = take && (w.r0_vld || w.r1_vld);
  assign q_data_o = w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpsd_pkg::PH_RIFF_ID; fcnt_q <= '0; id_q <= '0; size_q <= '0;
      rem_q <= '0; fmt_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0;
      acc_q <= '0; bis_q <= '0; cif_q <= '0; first_q <= '0; failed_q <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d; fcnt_q <= fcnt_d; id_q <= id_d; size_q <= size_d;
      rem_q <= rem_d; fmt_q <= fmt_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
      acc_q <= acc_d; bis_q <= bis_d; cif_q <= cif_d; first_q <= first_d;
      failed_q <= failed_d;
    end
  end

endmodule

/* src/wpsd_queue.sv */
// Short queue of work records between the front and back parts of the
// decoder. Uses wpsd_pkg.
module wpsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wpsd_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output wpsd_pkg::work_t head_o
);

  wpsd_pkg::work_t mem_q [wpsd_pkg::QDEPTH];
  logic [wpsd_pkg::QAW-1:0] wr_q, rd_q;
  logic [wpsd_pkg::QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (wpsd_pkg::QAW+1)'(wpsd_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
    end
  end

endmodule

/* src/wpsd_back.sv */
// Back part of the decoder: expands each work record into one or two result
// beats, averages stereo pairs and holds the output register. Uses wpsd_pkg.
module wpsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  wpsd_pkg::work_t  q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic signed [31:0] mono_sample_o,
  output logic [31:0]      rate_hz_o,
  output logic [15:0]      channel_count_o,
  output logic [5:0]       sample_bits_o,
  output logic [31:0]      payload_bytes_o,
  output logic             rate_warning_o,
  output logic [2:0]       error_code_o,
  output logic             end_of_run_o
);

  logic        sel_q, sel_d;       // 1 once the first result of the head is out
  logic        vld_q;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] mono_q, rate_q, pay_q;
  logic [31:0] mono_d, rate_d, pay_d;
  logic [15:0] ch_q, ch_d;
  logic [5:0]  bits_q, bits_d;
  logic        warn_q, eor_q;
  logic        warn_d, eor_d;
  logic [2:0]  err_q, err_d;

  logic        load, use_r1, have;
  logic [32:0] sum;
  logic [31:0] mono_n;

  assign have   = !q_empty_i;
  assign load   = have && (!vld_q || !out_stall_i);
  assign use_r1 = sel_q || !q_head_i.r0_vld;
  assign sel_d  = load && !use_r1 && q_head_i.r1_vld;
  assign q_pop_o = load && !sel_d;

  // Arithmetic shift of the 33-bit sum gives floor((L+R)/2).
  assign sum    = {q_head_i.r0_a[31], q_head_i.r0_a} + {q_head_i.r0_b[31], q_head_i.r0_b};
  assign mono_n = q_head_i.r0_avg ? sum[32:1] : q_head_i.r0_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; sel_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1; sel_q <= sel_d;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Fields that do not belong to the chosen result kind read as zero.
  always_comb begin
    mono_d = '0; rate_d = '0; pay_d = '0; ch_d = '0; bits_d = '0;
    warn_d = 1'b0;
    eor_d  = !sel_d;
    if (use_r1) begin
      kind_d = wpsd_pkg::KIND_ERROR;
      err_d  = q_head_i.r1_err;
    end else begin
      kind_d = q_head_i.r0_kind;
      err_d  = q_head_i.r0_err;
      case (q_head_i.r0_kind)
        wpsd_pkg::KIND_SAMPLE: mono_d = mono_n;
        wpsd_pkg::KIND_HEADER: begin
          rate_d = q_head_i.r0_a; pay_d = q_head_i.r0_b; ch_d = q_head_i.r0_ch;
          bits_d = q_head_i.r0_bits; warn_d = q_head_i.r0_warn;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= wpsd_pkg::KIND_SAMPLE; mono_q <= '0; rate_q <= '0; pay_q <= '0;
      ch_q <= '0; bits_q <= '0; warn_q <= 1'b0; err_q <= wpsd_pkg::ERR_NONE;
      eor_q <= 1'b0;
    end else if (load) begin
      kind_q <= kind_d; mono_q <= mono_d; rate_q <= rate_d; pay_q <= pay_d;
      ch_q <= ch_d; bits_q <= bits_d; warn_q <= warn_d; err_q <= err_d;
      eor_q <= eor_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign kind_o          = kind_q;
  assign mono_sample_o   = mono_q;
  assign rate_hz_o       = rate_q;
  assign channel_count_o = ch_q;
  assign sample_bits_o   = bits_q;
  assign payload_bytes_o = pay_q;
  assign rate_warning_o  = warn_q;
  assign error_code_o    = err_q;
  assign end_of_run_o    = eor_q;

endmodule

/* src/wav_pcm_stream_decoder.sv */
// WAV PCM stream decoder top level: ties the byte parser, the work queue and
// the result stage together. Uses wpsd_pkg, wpsd_front, wpsd_queue, wpsd_back.
//
// Usage: the input channel carries one byte of a RIFF/WAVE stream per beat,
// with last_byte_i marking the final byte. The output channel carries result
// beats: a header beat when the data chunk starts, one mono Q1.31 sample per
// complete frame (stereo is averaged, other counts keep the first channel),
// and error beats. end_of_run_o marks the last result caused by one byte.
// Throughput: one byte per cycle while the queue is not full. The parser keeps
// all header and sample state and decides on each byte combinationally; a byte
// that causes results leaves a record in a four-entry queue. The result stage
// drains a record one result beat at a time; a byte gives at most two results.
// A first result beat passes the queue memory, then the output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and once it is full in_stall_o rises; bytes that give no result
// still need a free queue slot to be taken. Reset empties the queue, drops
// any pending result and returns the parser to waiting for the RIFF id.
// A last_byte_i beat also returns the parser to that state after its results.
module wav_pcm_stream_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] mono_sample_o,
  output logic [31:0]        rate_hz_o,
  output logic [15:0]        channel_count_o,
  output logic [5:0]         sample_bits_o,
  output logic [31:0]        payload_bytes_o,
  output logic               rate_warning_o,
  output logic [2:0]         error_code_o,
  output logic               end_of_run_o
);

  wpsd_pkg::work_t push_data, head;
  logic push, full, pop, empty;

  wpsd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .last_byte_i,
    .q_full_i(full), .q_push_o(push), .q_data_o(push_data)
  );

  wpsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  wpsd_back u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .q_head_i(head), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .kind_o, .mono_sample_o, .rate_hz_o,
    .channel_count_o, .sample_bits_o, .payload_bytes_o, .rate_warning_o,
    .error_code_o, .end_of_run_o
  );

endmodule
